// File: rtl/core/jsu_pkg.sv
// Shared types, codes and helpers for the JSON string unescape block.
`timescale 1ns / 1ps
package jsu_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int CAP_W          = 16;
    localparam int OUT_CNT_W      = 16;
    localparam int MAX_RES        = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = 16'd256;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;

    localparam logic [7:0]  UTF_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF_CONT  = 8'h80;
    localparam logic [7:0]  UTF_MASK  = 8'h3F;
    localparam logic [15:0] UTF_LIM1  = 16'h0080;
    localparam logic [15:0] UTF_LIM2  = 16'h0800;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_STR  = 2'd1,
        MODE_ESC  = 2'd2,
        MODE_HEX  = 2'd3
    } mode_t;

    typedef struct packed {
        logic [7:0]           out_byte;
        logic [1:0]           kind;
        logic [OUT_CNT_W-1:0] count;
    } res_item_t;

    typedef struct packed {
        logic [1:0]                 num;
        res_item_t [MAX_RES-1:0]    item;
    } res_bundle_t;

    // {valid, value}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

// File: rtl/core/json_string_unescape_utf8.sv
// Top level of the JSON string literal decoder with UTF-8 output for \u escapes.
//
//  port group   dir  payload                               beat when
//  s_*          in   tdata in_byte, tuser start_req        s_tvalid & s_tready
//  m_*          out  tdata out_byte/byte_count, tuser kind m_tvalid & m_tready
//  cfg_*        in   cfg_data capacity                     cfg_valid & cfg_ready
//
// One input byte per cycle unless the output stalls or a multi-byte result
// is draining; a byte is registered, then decoded into the result buffer
// once it has room, and its results leave one per beat; a \u escape ending
// in a 2 or 3 byte sequence holds the input until the three-entry buffer is
// down to its last byte. Synchronous active-low reset; capacity resets to 256.
// Output stalls back up into the input register and then s_tready.
`timescale 1ns / 1ps
module json_string_unescape_utf8 #(
    parameter int COUNT_BITS = jsu_pkg::COUNT_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // [7:0] in_byte
    input  logic [0:0]                s_tuser,   // [0] start_req
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [23:0]               m_tdata,   // [7:0] out_byte, [23:8] byte_count
    output logic [1:0]                m_tuser,   // [1:0] kind
    output logic                      m_tlast,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [jsu_pkg::CAP_W-1:0] cfg_data
);
    import jsu_pkg::*;

    logic                  in_vld_reg;
    logic [7:0]            in_byte_reg;
    logic                  in_start_reg;
    logic [CAP_W-1:0]      cap_reg;
    mode_t                 mode_reg, mode_next;
    logic [1:0]            hex_cnt_reg, hex_cnt_next;
    logic [15:0]           cp_reg, cp_next;
    logic [COUNT_BITS-1:0] written_reg, written_next;
    res_bundle_t           res;
    logic                  buf_free;
    logic                  load;

    assign load      = in_vld_reg && buf_free;
    assign s_tready  = !in_vld_reg || load;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            cap_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_IDLE;
            hex_cnt_reg <= 2'd0;
            cp_reg      <= 16'd0;
            written_reg <= '0;
        end else if (load) begin
            mode_reg    <= mode_next;
            hex_cnt_reg <= hex_cnt_next;
            cp_reg      <= cp_next;
            written_reg <= written_next;
        end
    end

    jsu_decode #(
        .COUNT_BITS(COUNT_BITS)
    ) u_decode (
        .in_byte         (in_byte_reg),
        .start_req       (in_start_reg),
        .capacity        (cap_reg),
        .mode            (mode_reg),
        .hex_cnt         (hex_cnt_reg),
        .code_point      (cp_reg),
        .written         (written_reg),
        .mode_next       (mode_next),
        .hex_cnt_next    (hex_cnt_next),
        .code_point_next (cp_next),
        .written_next    (written_next),
        .res             (res)
    );

    jsu_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .res      (res),
        .free     (buf_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_DATA |-> m_tlast)
        else $error("done or error beat not marked last");

    a_end_no_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_DATA |-> m_tdata[7:0] == 8'd0)
        else $error("nonzero byte on done or error beat");

    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser != 2'd3)
        else $error("illegal kind");

    a_end_goes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        load && res.num != 2'd0 && res.item[0].kind != KIND_DATA
        |=> mode_reg == MODE_IDLE)
        else $error("decoder not idle after done or error");

endmodule

// File: rtl/core/jsu_decode.sv
// Next-state and result logic for one input byte of the string decoder.
`timescale 1ns / 1ps
module jsu_decode #(
    parameter int COUNT_BITS = jsu_pkg::COUNT_BITS_DEF
) (
    input  logic [7:0]                in_byte,
    input  logic                      start_req,
    input  logic [jsu_pkg::CAP_W-1:0] capacity,
    input  jsu_pkg::mode_t            mode,
    input  logic [1:0]                hex_cnt,
    input  logic [15:0]               code_point,
    input  logic [COUNT_BITS-1:0]     written,
    output jsu_pkg::mode_t            mode_next,
    output logic [1:0]                hex_cnt_next,
    output logic [15:0]               code_point_next,
    output logic [COUNT_BITS-1:0]     written_next,
    output jsu_pkg::res_bundle_t      res
);
    import jsu_pkg::*;

    localparam int CMP_W = ((COUNT_BITS > CAP_W) ? COUNT_BITS : CAP_W) + 1;

    logic [COUNT_BITS-1:0] w1, w2, w3;
    logic [CMP_W-1:0]      w_ext, cap_ext;
    logic                  room1, room2, room3;
    logic [4:0]            hv;
    logic [15:0]           cp_new;
    logic [7:0]            esc_byte;

    function automatic logic [OUT_CNT_W-1:0] to_out(input logic [COUNT_BITS-1:0] v);
        logic [CMP_W-1:0] e;
        e = CMP_W'(v);
        return e[OUT_CNT_W-1:0];
    endfunction

    assign w1      = written + COUNT_BITS'(1);
    assign w2      = written + COUNT_BITS'(2);
    assign w3      = written + COUNT_BITS'(3);
    assign w_ext   = CMP_W'(written);
    assign cap_ext = CMP_W'(capacity);
    assign room1   = (w_ext + CMP_W'(1)) < cap_ext;
    assign room2   = (w_ext + CMP_W'(2)) < cap_ext;
    assign room3   = (w_ext + CMP_W'(3)) < cap_ext;
    assign hv      = hex_val(in_byte);
    assign cp_new  = {code_point[11:0], hv[3:0]};

    always_comb begin
        case (in_byte)
            CH_N:    esc_byte = 8'h0A;
            CH_T:    esc_byte = 8'h09;
            CH_R:    esc_byte = 8'h0D;
            CH_B:    esc_byte = 8'h08;
            CH_F:    esc_byte = 8'h0C;
            default: esc_byte = in_byte;
        endcase
    end

    always_comb begin
        mode_next       = mode;
        hex_cnt_next    = hex_cnt;
        code_point_next = code_point;
        written_next    = written;
        res             = '0;

        if (start_req) begin
            written_next    = '0;
            hex_cnt_next    = 2'd0;
            code_point_next = 16'd0;
            if (in_byte != CH_QUOTE || capacity == '0) begin
                res.num           = 2'd1;
                res.item[0].kind  = KIND_ERR;
                mode_next         = MODE_IDLE;
            end else begin
                mode_next = MODE_STR;
            end
        end else begin
            unique case (mode)
                MODE_STR: begin
                    if (in_byte == CH_NUL || in_byte == CH_QUOTE || !room1) begin
                        res.num           = 2'd1;
                        res.item[0].kind  = (in_byte == CH_QUOTE) ? KIND_DONE : KIND_ERR;
                        res.item[0].count = to_out(written);
                        mode_next         = MODE_IDLE;
                    end else if (in_byte == CH_BSL) begin
                        mode_next = MODE_ESC;
                    end else begin
                        res.num               = 2'd1;
                        res.item[0].out_byte  = in_byte;
                        res.item[0].kind      = KIND_DATA;
                        res.item[0].count     = to_out(w1);
                        written_next          = w1;
                    end
                end
                MODE_ESC: begin
                    if (in_byte == CH_NUL) begin
                        res.num           = 2'd1;
                        res.item[0].kind  = KIND_ERR;
                        res.item[0].count = to_out(written);
                        mode_next         = MODE_IDLE;
                    end else if (in_byte == CH_U) begin
                        mode_next       = MODE_HEX;
                        hex_cnt_next    = 2'd0;
                        code_point_next = 16'd0;
                    end else begin
                        res.num              = 2'd1;
                        res.item[0].out_byte = esc_byte;
                        res.item[0].kind     = KIND_DATA;
                        res.item[0].count    = to_out(w1);
                        written_next         = w1;
                        mode_next            = MODE_STR;
                    end
                end
                MODE_HEX: begin
                    if (!hv[4]) begin
                        res.num           = 2'd1;
                        res.item[0].kind  = KIND_ERR;
                        res.item[0].count = to_out(written);
                        mode_next         = MODE_IDLE;
                    end else if (hex_cnt != 2'd3) begin
                        hex_cnt_next    = hex_cnt + 2'd1;
                        code_point_next = cp_new;
                    end else begin
                        hex_cnt_next    = 2'd0;
                        code_point_next = 16'd0;
                        mode_next       = MODE_STR;
                        if (cp_new < UTF_LIM1) begin
                            if (!room1) begin
                                res.num           = 2'd1;
                                res.item[0].kind  = KIND_ERR;
                                res.item[0].count = to_out(written);
                                mode_next         = MODE_IDLE;
                            end else begin
                                res.num              = 2'd1;
                                res.item[0].out_byte = cp_new[7:0];
                                res.item[0].count    = to_out(w1);
                                written_next         = w1;
                            end
                        end else if (cp_new < UTF_LIM2) begin
                            if (!room2) begin
                                res.num           = 2'd1;
                                res.item[0].kind  = KIND_ERR;
                                res.item[0].count = to_out(written);
                                mode_next         = MODE_IDLE;
                            end else begin
                                res.num              = 2'd2;
                                res.item[0].out_byte = UTF_LEAD2 | {3'd0, cp_new[10:6]};
                                res.item[0].count    = to_out(w1);
                                res.item[1].out_byte = UTF_CONT | (cp_new[7:0] & UTF_MASK);
                                res.item[1].count    = to_out(w2);
                                written_next         = w2;
                            end
                        end else begin
                            if (!room3) begin
                                res.num           = 2'd1;
                                res.item[0].kind  = KIND_ERR;
                                res.item[0].count = to_out(written);
                                mode_next         = MODE_IDLE;
                            end else begin
                                res.num              = 2'd3;
                                res.item[0].out_byte = UTF_LEAD3 | {4'd0, cp_new[15:12]};
                                res.item[0].count    = to_out(w1);
                                res.item[1].out_byte = UTF_CONT | (cp_new[13:6] & UTF_MASK);
                                res.item[1].count    = to_out(w2);
                                res.item[2].out_byte = UTF_CONT | (cp_new[7:0] & UTF_MASK);
                                res.item[2].count    = to_out(w3);
                                written_next         = w3;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// File: rtl/core/jsu_out_buf.sv
// Result buffer: holds the up to three results of one byte and drains one per beat.
`timescale 1ns / 1ps
module jsu_out_buf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  jsu_pkg::res_bundle_t res,
    output logic                 free,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,   // [7:0] out_byte, [23:8] byte_count
    output logic [1:0]           m_tuser,   // [1:0] kind
    output logic                 m_tlast
);
    import jsu_pkg::*;

    logic [1:0]              rem_reg, rem_next;
    logic [1:0]              ptr_reg, ptr_next;
    res_item_t [MAX_RES-1:0] item_reg;
    res_item_t               cur;

    assign cur      = item_reg[ptr_reg];
    assign m_tvalid = (rem_reg != 2'd0);
    assign m_tdata  = {cur.count, cur.out_byte};
    assign m_tuser  = cur.kind;
    assign m_tlast  = (rem_reg == 2'd1);
    assign free     = (rem_reg == 2'd0) || (rem_reg == 2'd1 && m_tready);

    always_comb begin
        rem_next = rem_reg;
        ptr_next = ptr_reg;
        if (load) begin
            rem_next = res.num;
            ptr_next = 2'd0;
        end else if (m_tvalid && m_tready) begin
            rem_next = rem_reg - 2'd1;
            ptr_next = ptr_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= 2'd0;
            ptr_reg <= 2'd0;
        end else begin
            rem_reg <= rem_next;
            ptr_reg <= ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= res.item;
        end
    end

endmodule

// File: verif/json_string_unescape_utf8_tb.sv
// Self-checking testbench for json_string_unescape_utf8 with a byte-level predictor.
`timescale 1ns / 1ps
module json_string_unescape_utf8_tb;
    import jsu_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 8;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CC_LF    = 8'h0A;
    localparam logic [7:0] CC_TAB   = 8'h09;
    localparam logic [7:0] CC_CR    = 8'h0D;
    localparam logic [7:0] CC_BS    = 8'h08;
    localparam logic [7:0] CC_FF    = 8'h0C;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } text_beat_t;

    typedef struct packed {
        logic [7:0]  data;
        logic [1:0]  kind;
        logic [15:0] count;
        logic        last;
    } out_rec_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic [0:0]  s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;   // [7:0] out_byte, [23:8] byte_count
    logic [1:0]  m_tuser;   // [1:0] kind
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = 16'h0000;

    text_beat_t text_q[$];
    out_rec_t   exp_q[$];

    // decoder state mirror
    mode_t       lit_mode = MODE_IDLE;
    logic [1:0]  hex_cnt  = 2'd0;
    logic [15:0] hex_acc  = 16'h0000;
    logic [15:0] out_cnt  = 16'h0000;
    logic [15:0] cap_q    = CAP_RESET;
    out_rec_t    step_res[3];
    int          step_n;

    bit idle_on    = 1'b1;
    bit hold_armed = 1'b0;
    bit src_beat   = 1'b0;
    int src_gap    = 0;
    int snk_stall  = 0;
    int cycle_n    = 0;
    int err_n      = 0;
    int sent_n     = 0;
    int n_data     = 0;
    int n_done     = 0;
    int n_err      = 0;

    json_string_unescape_utf8 dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        if (err_n < 30) begin
            $display("MISMATCH cycle %0d: %s got %0h expected %0h", cycle_n, what, got, want);
        end
        err_n++;
    endtask

    // ---------------- prediction ----------------

    function automatic int nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    function automatic bit fits(input int need);
        return (int'(out_cnt) + need) < int'(cap_q);
    endfunction

    task automatic emit_byte(input logic [7:0] b);
        out_cnt = out_cnt + 16'd1;
        step_res[step_n] = '{b, KIND_DATA, out_cnt, 1'b0};
        step_n++;
    endtask

    task automatic close_lit(input logic [1:0] k);
        step_res[step_n] = '{8'h00, k, out_cnt, 1'b0};
        step_n++;
        lit_mode = MODE_IDLE;
    endtask

    task automatic decode_step(input logic [7:0] c, input logic st);
        int          nib;
        logic [15:0] v;
        logic [7:0]  b;
        step_n = 0;
        if (st) begin
            out_cnt = 16'h0000;
            hex_cnt = 2'd0;
            hex_acc = 16'h0000;
            if (c != CH_QUOTE || cap_q == 16'd0) close_lit(KIND_ERR);
            else lit_mode = MODE_STR;
        end else begin
            case (lit_mode)
                MODE_STR: begin
                    if (c == CH_NUL) close_lit(KIND_ERR);
                    else if (c == CH_QUOTE) close_lit(KIND_DONE);
                    else if (!fits(1)) close_lit(KIND_ERR);
                    else if (c == CH_BSL) lit_mode = MODE_ESC;
                    else emit_byte(c);
                end
                MODE_ESC: begin
                    if (c == CH_NUL) begin
                        close_lit(KIND_ERR);
                    end else if (c == CH_U) begin
                        lit_mode = MODE_HEX;
                        hex_cnt  = 2'd0;
                        hex_acc  = 16'h0000;
                    end else begin
                        case (c)
                            CH_N:    b = CC_LF;
                            CH_T:    b = CC_TAB;
                            CH_R:    b = CC_CR;
                            CH_B:    b = CC_BS;
                            CH_F:    b = CC_FF;
                            default: b = c;
                        endcase
                        lit_mode = MODE_STR;
                        emit_byte(b);
                    end
                end
                MODE_HEX: begin
                    nib = nibble_of(c);
                    if (nib < 0) begin
                        close_lit(KIND_ERR);
                    end else begin
                        hex_acc = {hex_acc[11:0], 4'(nib)};
                        if (hex_cnt != 2'd3) begin
                            hex_cnt = hex_cnt + 2'd1;
                        end else begin
                            v        = hex_acc;
                            hex_cnt  = 2'd0;
                            hex_acc  = 16'h0000;
                            lit_mode = MODE_STR;
                            if (v < UTF_LIM1) begin
                                if (!fits(1)) close_lit(KIND_ERR);
                                else emit_byte(v[7:0]);
                            end else if (v < UTF_LIM2) begin
                                if (!fits(2)) begin
                                    close_lit(KIND_ERR);
                                end else begin
                                    emit_byte(UTF_LEAD2 | 8'(v >> 6));
                                    emit_byte(UTF_CONT | (v[7:0] & UTF_MASK));
                                end
                            end else begin
                                if (!fits(3)) begin
                                    close_lit(KIND_ERR);
                                end else begin
                                    emit_byte(UTF_LEAD3 | 8'(v >> 12));
                                    emit_byte(UTF_CONT | (8'(v >> 6) & UTF_MASK));
                                    emit_byte(UTF_CONT | (v[7:0] & UTF_MASK));
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
        for (int i = 0; i < step_n; i++) begin
            step_res[i].last = (i == step_n - 1);
            exp_q.push_back(step_res[i]);
        end
    endtask

    // ---------------- stimulus helpers ----------------

    task automatic push_byte(input logic [7:0] c, input logic st);
        text_q.push_back('{c, st});
        sent_n++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i], i == 0);
    endtask

    function automatic logic [7:0] hex_char(input int nib);
        if (nib < 10) return 8'(int'("0") + nib);
        if ($urandom_range(0, 1)) return 8'(int'("a") + nib - 10);
        return 8'(int'("A") + nib - 10);
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE || c == CH_BSL);
        return c;
    endfunction

    function automatic logic [7:0] non_hex();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (nibble_of(c) >= 0);
        return c;
    endfunction

    function automatic logic [7:0] escape_char(input int k);
        case (k)
            0:       return CH_N;
            1:       return CH_T;
            2:       return CH_R;
            3:       return CH_B;
            4:       return CH_F;
            5:       return CH_BSL;
            6:       return CH_QUOTE;
            default: return CH_SLASH;
        endcase
    endfunction

    function automatic logic [15:0] pick_code();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 'h7F));
            1:       return 16'($urandom_range('h80, 'h7FF));
            2:       return 16'($urandom_range('h800, 'hFFFF));
            default: return 16'($urandom_range('hD800, 'hDFFF));
        endcase
    endfunction

    task automatic push_code(input logic [15:0] v);
        push_byte(CH_BSL, 1'b0);
        push_byte(CH_U, 1'b0);
        for (int i = 3; i >= 0; i--) push_byte(hex_char(int'(v[i*4 +: 4])), 1'b0);
    endtask

    task automatic add_fault();
        logic [7:0] c;
        case ($urandom_range(0, 4))
            0: push_byte(CH_NUL, 1'b0);
            1: begin
                push_byte(CH_BSL, 1'b0);
                push_byte(CH_NUL, 1'b0);
            end
            2: begin
                push_byte(CH_BSL, 1'b0);
                push_byte(CH_U, 1'b0);
                repeat ($urandom_range(0, 3)) push_byte(hex_char($urandom_range(0, 15)), 1'b0);
                push_byte(non_hex(), 1'b0);
            end
            3: begin
                do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE);
                push_byte(c, 1'b1);
                repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(0, 255)), 1'b0);
            end
            default: ; // left open, the next start abandons it
        endcase
    endtask

    task automatic add_literal(input bit broken);
        int len;
        int fault_at;
        len      = $urandom_range(0, 10);
        fault_at = broken ? $urandom_range(0, len) : -1;
        push_byte(CH_QUOTE, 1'b1);
        for (int i = 0; i < len; i++) begin
            if (i == fault_at) begin
                add_fault();
                return;
            end
            case ($urandom_range(0, 5))
                0, 1: push_byte(plain_char(), 1'b0);
                2: begin
                    push_byte(CH_BSL, 1'b0);
                    push_byte(escape_char($urandom_range(0, 7)), 1'b0);
                end
                3: begin
                    push_byte(CH_BSL, 1'b0);
                    push_byte(8'($urandom_range(1, CH_U - 1)), 1'b0);
                end
                default: push_code(pick_code());
            endcase
        end
        if (fault_at == len) add_fault();
        else push_byte(CH_QUOTE, 1'b0);
    endtask

    task automatic add_random(input int bytes);
        int stop;
        stop = sent_n + bytes;
        while (sent_n < stop) add_literal($urandom_range(0, 6) == 0);
    endtask

    task automatic wait_idle();
        while (text_q.size() != 0 || s_tvalid || exp_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_capacity(input logic [15:0] v);
        @(negedge aclk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cap_q = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // ---------------- driver, receiver, monitor ----------------

    always @(negedge aclk) begin
        text_beat_t nxt;
        if (aresetn && (!s_tvalid || src_beat)) begin
            if (src_gap > 0) begin
                src_gap--;
                s_tvalid <= 1'b0;
            end else if (text_q.size() != 0 && idle_on && $urandom_range(0, 9) == 0) begin
                src_gap = $urandom_range(0, 15);
                s_tvalid <= 1'b0;
            end else if (text_q.size() != 0) begin
                nxt = text_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.data;
                s_tuser  <= nxt.start;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (snk_stall > 0) begin
            snk_stall--;
            m_tready <= 1'b0;
        end else if (hold_armed) begin
            hold_armed = 1'b0;
            snk_stall  = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            snk_stall = $urandom_range(0, 15);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        out_rec_t want;
        cycle_n++;
        src_beat = aresetn && s_tvalid && s_tready;
        if (src_beat) decode_step(s_tdata, s_tuser[0]);
        if (aresetn && m_tvalid && m_tready) begin
            if (exp_q.size() == 0) begin
                report("result beat with nothing pending, tdata", 32'(m_tdata), 32'h0);
            end else begin
                want = exp_q.pop_front();
                if (m_tdata[7:0] !== want.data) begin
                    report("out_byte", 32'(m_tdata[7:0]), 32'(want.data));
                end
                if (m_tdata[23:8] !== want.count) begin
                    report("byte_count", 32'(m_tdata[23:8]), 32'(want.count));
                end
                if (m_tuser !== want.kind) report("kind", 32'(m_tuser), 32'(want.kind));
                if (m_tlast !== want.last) report("tlast", 32'(m_tlast), 32'(want.last));
                case (want.kind)
                    KIND_DATA: n_data++;
                    KIND_DONE: n_done++;
                    default:   n_err++;
                endcase
            end
        end
        if (cycle_n >= CYCLE_LIMIT) begin
            $display("Timeout at cycle %0d with %0d results pending", cycle_n, exp_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed, reset capacity
        push_text("\"\"");
        push_text("\"Az\\n\\t\\r\\b\\f\\\\\\\"\\/\\q\"");
        push_text("\"\\u0041\\u07ff\\u0800\\uFFFF\\uD83D\\u00e9\\u0000\\u007F\\u0080\"");
        push_text("x");
        push_byte(8'hFF, 1'b0);
        push_byte(CH_NUL, 1'b0);
        push_text("\"ab");
        push_byte(8'hFF, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(CH_NUL, 1'b0);
        push_text("\"\\");
        push_byte(CH_NUL, 1'b0);
        push_text("\"\\u12");
        push_byte(CH_NUL, 1'b0);
        push_text("\"\\u1G");
        push_text("\"abc");
        push_text("\"d\"");
        wait_idle();

        set_capacity(16'd0);
        push_text("\"a\"");
        push_text("\"\"");
        wait_idle();

        set_capacity(16'd1);
        push_text("\"\"");
        push_text("\"a\"");
        push_text("\"\\u0041\"");
        wait_idle();

        set_capacity(16'd3);
        push_text("\"\\u00e9\"");
        push_text("\"\\u20AC\"");
        push_text("\"ab\\n\"");
        push_text("\"a\\u0041\"");
        wait_idle();

        set_capacity(16'd4);
        push_text("\"\\u20AC\"");
        push_text("\"a\\u20ac\"");
        wait_idle();

        // random: widest capacity, output held off long enough to back up the input
        set_capacity(16'hFFFF);
        hold_armed = 1'b1;
        add_random(45);
        wait_idle();

        set_capacity(16'($urandom_range(2, 20)));
        add_random(40);
        wait_idle();

        // no idling on either side
        set_capacity(CAP_RESET);
        idle_on = 1'b0;
        add_random(45);
        wait_idle();

        $display("Sent %0d input bytes over capacities 256, 0, 1, 3, 4, 65535",
                 sent_n);
        $display("and a small random one; checked %0d data bytes, %0d done, %0d errors",
                 n_data, n_done, n_err);
        if (err_n == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
